// ===== hw/rtl/assert_macros.svh =====
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent holds in a cycle, consequent holds in the same cycle
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent holds in a cycle, consequent holds in the next cycle
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/atct_pkg.sv =====
// shared types, constants and codes of the at command transactor
package atct_pkg;

    localparam int CMD_LEN     = 32;
    localparam int WIN_DEPTH   = CMD_LEN + 3;
    localparam int IDX_W       = $clog2(CMD_LEN);
    localparam int LEN_W       = $clog2(CMD_LEN + 1);
    localparam int WIN_IDX_W   = $clog2(WIN_DEPTH);
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic [1:0] FUNC_LOAD  = 2'd0;
    localparam logic [1:0] FUNC_START = 2'd1;
    localparam logic [1:0] FUNC_RX    = 2'd2;
    localparam logic [1:0] FUNC_TICK  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_INIT_ECHO_TIMEOUT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ECHO_TIMEOUT      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GUARD_TIME        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_NOOP_DELAY        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RETRY_LIMIT       = 3'd4;

    localparam logic [15:0] RST_INIT_ECHO_TIMEOUT = 16'd500;
    localparam logic [15:0] RST_ECHO_TIMEOUT      = 16'd5000;
    localparam logic [15:0] RST_GUARD_TIME        = 16'd250;
    localparam logic [15:0] RST_NOOP_DELAY        = 16'd10;
    localparam logic [3:0]  RST_RETRY_LIMIT       = 4'd3;

    localparam logic [1:0] OUT_OK    = 2'd0;
    localparam logic [1:0] OUT_ERROR = 2'd1;
    localparam logic [1:0] OUT_SYNCH = 2'd2;

    localparam logic KIND_TX   = 1'b0;
    localparam logic KIND_DONE = 1'b1;

    localparam logic [1:0] JOB_CMD  = 2'd0;
    localparam logic [1:0] JOB_PLUS = 2'd1;
    localparam logic [1:0] JOB_DONE = 2'd2;

    localparam logic [7:0]  CHAR_CR    = 8'h0D;
    localparam logic [7:0]  CHAR_LF    = 8'h0A;
    localparam logic [7:0]  CHAR_PLUS  = 8'h2B;
    localparam logic [15:0] OK_TEXT    = 16'h4F4B;
    localparam logic [39:0] ERROR_TEXT = 40'h4552524F52;

    typedef logic [7:0] byte_t;

    typedef struct packed {
        logic [1:0]       code;
        logic [1:0]       outcome;
        logic [LEN_W-1:0] len;
    } job_t;

endpackage

// ===== hw/rtl/atct_front.sv =====
// front end: config registers, command store, exchange control and echo/reply matching
`include "assert_macros.svh"

module atct_front
    import atct_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [1:0]            func,
    input  byte_t                 data_byte,
    input  logic                  init_flag,
    input  logic                  q_full,
    input  logic                  back_quiet,
    output logic                  push,
    output job_t                  job,
    input  logic [IDX_W-1:0]      rd_addr,
    output byte_t                 rd_data
);

    localparam logic [2:0] PH_IDLE  = 3'd0;
    localparam logic [2:0] PH_SEND  = 3'd1;
    localparam logic [2:0] PH_REPLY = 3'd2;
    localparam logic [2:0] PH_PLUS1 = 3'd3;
    localparam logic [2:0] PH_PLUS2 = 3'd4;
    localparam logic [2:0] PH_PLUS3 = 3'd5;
    localparam logic [2:0] PH_NOOP  = 3'd6;

    logic [15:0] init_to_reg, echo_to_reg, guard_reg, noop_reg;
    logic [3:0]  limit_reg;

    logic [2:0]           phase_reg, phase_next;
    logic [LEN_W-1:0]     len_reg, len_next;
    logic                 init_reg, init_next;
    logic [3:0]           retries_reg, retries_next;
    logic [15:0]          count_reg, count_next;
    logic [WIN_DEPTH-1:0] match_reg, match_next;
    logic [39:0]          reply_reg, reply_next;
    logic [2:0]           fill_reg, fill_next;
    byte_t                store_reg [CMD_LEN];

    logic                 accept;
    logic                 store_we;
    logic [WIN_DEPTH-1:0] match_prev, match_step;
    logic [WIN_IDX_W-1:0] len_w, lane_pos;
    byte_t                lane_byte;
    logic                 echo_hit;
    logic [39:0]          reply_shift;
    logic [2:0]           fill_step;
    logic                 ok_hit, error_hit;
    logic [3:0]           retries_inc;

    logic                 do_send, do_plus, do_finish, clear_win;
    logic [15:0]          send_to;
    logic [2:0]           plus_phase;
    logic [1:0]           fin_outcome;

    assign accept   = in_valid && in_ready;
    assign in_ready = !q_full && (func != FUNC_LOAD || back_quiet);
    assign rd_data  = store_reg[rd_addr];

    // echo matcher: bit j set when the last j+1 bytes match the echo prefix
    assign len_w      = WIN_IDX_W'(len_reg);
    assign match_prev = {match_reg[WIN_DEPTH-2:0], 1'b1};

    always_comb
    begin
        lane_pos  = '0;
        lane_byte = '0;
        for (int j = 0; j < WIN_DEPTH; j++)
        begin
            lane_pos = WIN_IDX_W'(j);
            if (lane_pos < len_w)
            begin
                lane_byte = store_reg[IDX_W'(j)];
            end
            else if (lane_pos == len_w || lane_pos == len_w + WIN_IDX_W'(1))
            begin
                lane_byte = CHAR_CR;
            end
            else
            begin
                lane_byte = CHAR_LF;
            end
            match_step[j] = match_prev[j] && (lane_byte == data_byte);
        end
    end

    assign echo_hit = match_step[len_w + WIN_IDX_W'(2)];

    // reply matcher over the last five bytes
    assign reply_shift = {reply_reg[31:0], data_byte};
    assign fill_step   = (fill_reg >= 3'd5) ? 3'd5 : fill_reg + 3'd1;
    assign ok_hit      = (fill_step >= 3'd2) && (reply_shift[15:0] == OK_TEXT);
    assign error_hit   = (fill_step == 3'd5) && (reply_shift == ERROR_TEXT);
    assign retries_inc = retries_reg + 4'd1;

    always_comb
    begin
        phase_next   = phase_reg;
        len_next     = len_reg;
        init_next    = init_reg;
        retries_next = retries_reg;
        count_next   = count_reg;
        match_next   = match_reg;
        reply_next   = reply_reg;
        fill_next    = fill_reg;
        store_we     = 1'b0;
        do_send      = 1'b0;
        do_plus      = 1'b0;
        do_finish    = 1'b0;
        clear_win    = 1'b0;
        send_to      = echo_to_reg;
        plus_phase   = PH_PLUS1;
        fin_outcome  = OUT_OK;

        if (accept)
        begin
            case (func)
                FUNC_LOAD:
                begin
                    if (phase_reg == PH_IDLE && len_reg < LEN_W'(CMD_LEN))
                    begin
                        store_we = 1'b1;
                        len_next = len_reg + LEN_W'(1);
                    end
                end
                FUNC_START:
                begin
                    if (phase_reg == PH_IDLE)
                    begin
                        init_next    = init_flag;
                        retries_next = '0;
                        clear_win    = 1'b1;
                        if (len_reg != '0)
                        begin
                            do_send = 1'b1;
                            send_to = init_flag ? init_to_reg : echo_to_reg;
                        end
                        else if (init_flag)
                        begin
                            do_plus    = 1'b1;
                            plus_phase = PH_PLUS1;
                        end
                        else
                        begin
                            phase_next = PH_NOOP;
                            count_next = noop_reg;
                        end
                    end
                end
                FUNC_RX:
                begin
                    if (phase_reg == PH_SEND)
                    begin
                        if (echo_hit)
                        begin
                            phase_next = PH_REPLY;
                            clear_win  = 1'b1;
                        end
                        else
                        begin
                            match_next = match_step;
                        end
                    end
                    else if (phase_reg == PH_REPLY)
                    begin
                        reply_next = reply_shift;
                        fill_next  = fill_step;
                        if (ok_hit)
                        begin
                            do_finish   = 1'b1;
                            fin_outcome = OUT_OK;
                        end
                        else if (error_hit)
                        begin
                            do_finish   = 1'b1;
                            fin_outcome = OUT_ERROR;
                        end
                    end
                end
                default:
                begin
                    if (phase_reg != PH_IDLE)
                    begin
                        if (count_reg <= 16'd1)
                        begin
                            count_next = '0;
                            case (phase_reg)
                                PH_SEND, PH_REPLY:
                                begin
                                    if (init_reg)
                                    begin
                                        do_finish = 1'b1;
                                    end
                                    else if (retries_inc >= limit_reg)
                                    begin
                                        do_finish   = 1'b1;
                                        fin_outcome = OUT_SYNCH;
                                    end
                                    else
                                    begin
                                        retries_next = retries_inc;
                                        do_plus      = 1'b1;
                                        plus_phase   = PH_PLUS1;
                                    end
                                end
                                PH_PLUS1:
                                begin
                                    do_plus    = 1'b1;
                                    plus_phase = PH_PLUS2;
                                end
                                PH_PLUS2:
                                begin
                                    do_plus    = 1'b1;
                                    plus_phase = PH_PLUS3;
                                end
                                PH_PLUS3:
                                begin
                                    if (len_reg != '0)
                                    begin
                                        do_send = 1'b1;
                                        send_to = echo_to_reg;
                                    end
                                    else
                                    begin
                                        do_finish = 1'b1;
                                    end
                                end
                                PH_NOOP:
                                begin
                                    do_finish = 1'b1;
                                end
                                default:
                                begin
                                    do_finish = 1'b0;
                                end
                            endcase
                        end
                        else
                        begin
                            count_next = count_reg - 16'd1;
                        end
                    end
                end
            endcase
        end

        if (do_send)
        begin
            phase_next = PH_SEND;
            count_next = send_to;
            clear_win  = 1'b1;
        end
        if (do_plus)
        begin
            phase_next = plus_phase;
            count_next = guard_reg;
        end
        if (do_finish)
        begin
            phase_next   = PH_IDLE;
            len_next     = '0;
            retries_next = '0;
            count_next   = '0;
            clear_win    = 1'b1;
        end
        if (clear_win)
        begin
            match_next = '0;
            fill_next  = '0;
        end
    end

    always_comb
    begin
        push        = do_send || do_plus || do_finish;
        job.len     = len_reg;
        job.outcome = fin_outcome;
        if (do_send)
        begin
            job.code = JOB_CMD;
        end
        else if (do_plus)
        begin
            job.code = JOB_PLUS;
        end
        else
        begin
            job.code = JOB_DONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_to_reg <= RST_INIT_ECHO_TIMEOUT;
            echo_to_reg <= RST_ECHO_TIMEOUT;
            guard_reg   <= RST_GUARD_TIME;
            noop_reg    <= RST_NOOP_DELAY;
            limit_reg   <= RST_RETRY_LIMIT;
            phase_reg   <= PH_IDLE;
            len_reg     <= '0;
            init_reg    <= 1'b0;
            retries_reg <= '0;
            count_reg   <= '0;
            match_reg   <= '0;
            fill_reg    <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_INIT_ECHO_TIMEOUT: init_to_reg <= cfg_data;
                    REG_ECHO_TIMEOUT:      echo_to_reg <= cfg_data;
                    REG_GUARD_TIME:        guard_reg   <= cfg_data;
                    REG_NOOP_DELAY:        noop_reg    <= cfg_data;
                    REG_RETRY_LIMIT:       limit_reg   <= cfg_data[3:0];
                    default:               limit_reg   <= limit_reg;
                endcase
            end
            phase_reg   <= phase_next;
            len_reg     <= len_next;
            init_reg    <= init_next;
            retries_reg <= retries_next;
            count_reg   <= count_next;
            match_reg   <= match_next;
            fill_reg    <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        reply_reg <= reply_next;
        if (store_we)
        begin
            store_reg[len_reg[IDX_W-1:0]] <= data_byte;
        end
    end

    `ASSERT_IMPLIES(a_len_bound, 1'b1, len_reg <= LEN_W'(CMD_LEN), "command length overran store")
    `ASSERT_IMPLIES(a_busy_has_cmd, phase_reg == PH_SEND || phase_reg == PH_REPLY, len_reg != '0, "echo wait without command")
    `ASSERT_IMPLIES(a_load_when_quiet, store_we, back_quiet, "store written while back end reads it")

endmodule

// ===== hw/rtl/atct_queue.sv =====
// short job queue between front and back end
`include "assert_macros.svh"

module atct_queue
    import atct_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t wr_job,
    input  logic pop,
    output job_t rd_job,
    output logic full,
    output logic empty
);

    job_t              mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] cnt_reg;

    assign full   = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty  = (cnt_reg == '0);
    assign rd_job = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                        : wr_ptr_reg + QPTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                        : rd_ptr_reg + QPTR_W'(1);
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + QCNT_W'(1);
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - QCNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wr_job;
        end
    end

    `ASSERT_IMPLIES(a_no_overflow, push, !full, "job pushed into full queue")
    `ASSERT_IMPLIES(a_no_underflow, pop, !empty, "job popped from empty queue")

endmodule

// ===== hw/rtl/atct_back.sv =====
// back end: turns jobs into result beats through an output register
`include "assert_macros.svh"

module atct_back
    import atct_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_empty,
    output logic             q_pop,
    input  job_t             q_job,
    output logic [IDX_W-1:0] rd_addr,
    input  byte_t            rd_data,
    output logic             back_quiet,
    output logic             out_valid,
    input  logic             out_ready,
    output logic             kind,
    output byte_t            tx_byte,
    output logic [1:0]       outcome,
    output logic             last
);

    logic             busy_reg, busy_next;
    job_t             job_reg;
    logic [LEN_W-1:0] idx_reg, idx_next;
    logic             valid_reg;
    logic             kind_reg;
    byte_t            tx_reg;
    logic [1:0]       outcome_reg;
    logic             last_reg;

    logic             slot_free;
    logic             emit;
    logic             emit_kind;
    byte_t            emit_tx;
    logic [1:0]       emit_outcome;
    logic             emit_last;

    assign slot_free  = !valid_reg || out_ready;
    assign q_pop      = !busy_reg && !q_empty;
    assign rd_addr    = idx_reg[IDX_W-1:0];
    assign back_quiet = !busy_reg && q_empty;

    always_comb
    begin
        busy_next    = busy_reg;
        idx_next     = idx_reg;
        emit         = 1'b0;
        emit_kind    = KIND_TX;
        emit_tx      = '0;
        emit_outcome = OUT_OK;
        emit_last    = 1'b0;
        if (busy_reg && slot_free)
        begin
            case (job_reg.code)
                JOB_CMD:
                begin
                    emit = 1'b1;
                    if (idx_reg < job_reg.len)
                    begin
                        emit_tx  = rd_data;
                        idx_next = idx_reg + LEN_W'(1);
                    end
                    else
                    begin
                        emit_tx   = CHAR_CR;
                        emit_last = 1'b1;
                        busy_next = 1'b0;
                    end
                end
                JOB_PLUS:
                begin
                    emit      = 1'b1;
                    emit_tx   = CHAR_PLUS;
                    emit_last = 1'b1;
                    busy_next = 1'b0;
                end
                JOB_DONE:
                begin
                    emit         = 1'b1;
                    emit_kind    = KIND_DONE;
                    emit_outcome = job_reg.outcome;
                    emit_last    = 1'b1;
                    busy_next    = 1'b0;
                end
                default:
                begin
                    busy_next = 1'b0;
                end
            endcase
        end
        else if (q_pop)
        begin
            busy_next = 1'b1;
            idx_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
            if (emit)
            begin
                valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            job_reg <= q_job;
        end
        if (emit)
        begin
            kind_reg    <= emit_kind;
            tx_reg      <= emit_tx;
            outcome_reg <= emit_outcome;
            last_reg    <= emit_last;
        end
    end

    assign out_valid = valid_reg;
    assign kind      = kind_reg;
    assign tx_byte   = tx_reg;
    assign outcome   = outcome_reg;
    assign last      = last_reg;

    `ASSERT_NEXT(a_last_frees_back, emit && emit_last, !busy_reg, "back end busy after final beat")

endmodule

// ===== hw/rtl/at_command_transactor.sv =====
// at command transactor: front end, job queue and back end
// an item is taken when the job queue has room; loads wait until the back end drains
// a result beat passes through the job queue, the back end job register and the output register
// a command send gives command length + 1 beats, one per cycle unless out_ready stalls the back end
// other items give at most one beat; one item per cycle while the queue has room; jobs do not overlap
// reset: registers to defaults, exchange idle, queue and output empty, command store undefined

module at_command_transactor
    import atct_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [1:0]            func,
    input  logic [7:0]            data_byte,
    input  logic                  init_flag,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  kind,
    output logic [7:0]            tx_byte,
    output logic [1:0]            outcome,
    output logic                  last
);

    logic             q_full, q_empty, q_push, q_pop, back_quiet;
    job_t             push_job, pop_job;
    logic [IDX_W-1:0] rd_addr;
    byte_t            rd_data;

    atct_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .func       (func),
        .data_byte  (data_byte),
        .init_flag  (init_flag),
        .q_full     (q_full),
        .back_quiet (back_quiet),
        .push       (q_push),
        .job        (push_job),
        .rd_addr    (rd_addr),
        .rd_data    (rd_data)
    );

    atct_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (q_push),
        .wr_job (push_job),
        .pop    (q_pop),
        .rd_job (pop_job),
        .full   (q_full),
        .empty  (q_empty)
    );

    atct_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (q_empty),
        .q_pop      (q_pop),
        .q_job      (pop_job),
        .rd_addr    (rd_addr),
        .rd_data    (rd_data),
        .back_quiet (back_quiet),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .kind       (kind),
        .tx_byte    (tx_byte),
        .outcome    (outcome),
        .last       (last)
    );

endmodule

// ===== tb/sv/at_command_transactor_tb.sv =====
// testbench for the at command transactor: directed items and random AT exchanges checked against a built-in predictor
`timescale 1ns / 100ps

module at_command_transactor_tb;
    import atct_pkg::*;

    localparam int DUE_DEPTH = 256;

    typedef enum logic [2:0] {
        EX_IDLE,
        EX_SEND,
        EX_REPLY,
        EX_PLUS1,
        EX_PLUS2,
        EX_PLUS3,
        EX_NOOP
    } xchg_phase_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] tx_byte;
        logic [1:0] outcome;
        logic       last;
    } beat_t;

    typedef struct packed {
        logic [1:0] f;
        byte_t      d;
        logic       flag;
    } stim_t;

    class exchange_scoreboard;
        logic [15:0] init_echo_ticks;
        logic [15:0] echo_ticks;
        logic [15:0] guard_ticks;
        logic [15:0] noop_ticks;
        logic [3:0]  retry_max;
        xchg_phase_t xphase;
        byte_t       cmd_mem [CMD_LEN];
        int          cmd_len;
        logic        init_cmd;
        logic [3:0]  retry_cnt;
        logic [15:0] ticks_left;
        byte_t       rx_win [WIN_DEPTH];
        int          rx_fill;
        beat_t       due_beats [DUE_DEPTH];
        int          due_head;
        int          due_count;
        int          fails;

        function new();
            init_echo_ticks = RST_INIT_ECHO_TIMEOUT;
            echo_ticks      = RST_ECHO_TIMEOUT;
            guard_ticks     = RST_GUARD_TIME;
            noop_ticks      = RST_NOOP_DELAY;
            retry_max       = RST_RETRY_LIMIT;
            xphase          = EX_IDLE;
            cmd_len         = 0;
            init_cmd        = 1'b0;
            retry_cnt       = '0;
            ticks_left      = '0;
            rx_fill         = 0;
            due_head        = 0;
            due_count       = 0;
            fails           = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] value);
            case (idx)
                REG_INIT_ECHO_TIMEOUT: init_echo_ticks = value;
                REG_ECHO_TIMEOUT:      echo_ticks = value;
                REG_GUARD_TIME:        guard_ticks = value;
                REG_NOOP_DELAY:        noop_ticks = value;
                REG_RETRY_LIMIT:       retry_max = value[3:0];
                default: ;
            endcase
        endfunction

        function void emit(logic k, byte_t b, logic [1:0] oc);
            beat_t bt;
            bt = '{k, b, oc, 1'b0};
            due_beats[(due_head + due_count) % DUE_DEPTH] = bt;
            due_count++;
        endfunction

        function void send_cmd(logic [15:0] timeout);
            int i;
            for (i = 0; i < cmd_len; i++)
                emit(KIND_TX, cmd_mem[i], OUT_OK);
            emit(KIND_TX, CHAR_CR, OUT_OK);
            rx_fill = 0;
            xphase = EX_SEND;
            ticks_left = timeout;
        endfunction

        function void send_plus(xchg_phase_t next);
            xphase = next;
            ticks_left = guard_ticks;
            emit(KIND_TX, CHAR_PLUS, OUT_OK);
        endfunction

        function void finish(logic [1:0] oc);
            emit(KIND_DONE, 8'h00, oc);
            xphase = EX_IDLE;
            cmd_len = 0;
            retry_cnt = '0;
            ticks_left = '0;
            rx_fill = 0;
        endfunction

        function void rx_push(byte_t b);
            int i;
            if (rx_fill < WIN_DEPTH)
            begin
                rx_win[rx_fill] = b;
                rx_fill++;
            end
            else
            begin
                for (i = 0; i < WIN_DEPTH - 1; i++)
                    rx_win[i] = rx_win[i + 1];
                rx_win[WIN_DEPTH - 1] = b;
            end
        endfunction

        function bit rx_tail(logic [39:0] text, int n);
            int i;
            if (rx_fill < n)
                return 1'b0;
            for (i = 0; i < n; i++)
                if (rx_win[rx_fill - n + i] != text[8 * (n - 1 - i) +: 8])
                    return 1'b0;
            return 1'b1;
        endfunction

        // returns 0 when the block ignores the item
        function bit note_item(logic [1:0] f, byte_t d, logic flag);
            int    start_count;
            int    base;
            int    i;
            bit    echo_ok;
            bit    taken;
            start_count = due_count;
            taken = 1'b1;
            case (f)
                FUNC_LOAD:
                    if (xphase == EX_IDLE && cmd_len < CMD_LEN)
                    begin
                        cmd_mem[cmd_len] = d;
                        cmd_len++;
                    end
                    else
                        taken = 1'b0;
                FUNC_START:
                    if (xphase != EX_IDLE)
                        taken = 1'b0;
                    else
                    begin
                        init_cmd = flag;
                        retry_cnt = '0;
                        rx_fill = 0;
                        if (cmd_len > 0)
                            send_cmd(flag ? init_echo_ticks : echo_ticks);
                        else if (flag)
                            send_plus(EX_PLUS1);
                        else
                        begin
                            xphase = EX_NOOP;
                            ticks_left = noop_ticks;
                        end
                    end
                FUNC_RX:
                    if (xphase == EX_SEND)
                    begin
                        rx_push(d);
                        echo_ok = (rx_fill >= cmd_len + 3);
                        if (echo_ok)
                        begin
                            base = rx_fill - cmd_len - 3;
                            for (i = 0; i < cmd_len; i++)
                                if (rx_win[base + i] != cmd_mem[i])
                                    echo_ok = 1'b0;
                            if (rx_win[base + cmd_len] != CHAR_CR ||
                                rx_win[base + cmd_len + 1] != CHAR_CR ||
                                rx_win[base + cmd_len + 2] != CHAR_LF)
                                echo_ok = 1'b0;
                        end
                        if (echo_ok)
                        begin
                            rx_fill = 0;
                            xphase = EX_REPLY;
                        end
                    end
                    else if (xphase == EX_REPLY)
                    begin
                        rx_push(d);
                        if (rx_tail(OK_TEXT, 2))
                            finish(OUT_OK);
                        else if (rx_tail(ERROR_TEXT, 5))
                            finish(OUT_ERROR);
                    end
                    else
                        taken = 1'b0;
                default:
                    if (xphase == EX_IDLE)
                        taken = 1'b0;
                    else if (ticks_left <= 16'd1)
                    begin
                        ticks_left = '0;
                        case (xphase)
                            EX_SEND, EX_REPLY:
                                if (init_cmd)
                                    finish(OUT_OK);
                                else
                                begin
                                    retry_cnt++;
                                    if (retry_cnt >= retry_max)
                                        finish(OUT_SYNCH);
                                    else
                                        send_plus(EX_PLUS1);
                                end
                            EX_PLUS1: send_plus(EX_PLUS2);
                            EX_PLUS2: send_plus(EX_PLUS3);
                            EX_PLUS3:
                                if (cmd_len > 0)
                                    send_cmd(echo_ticks);
                                else
                                    finish(OUT_OK);
                            default: finish(OUT_OK);
                        endcase
                    end
                    else
                        ticks_left--;
            endcase
            if (due_count > start_count)
                due_beats[(due_head + due_count - 1) % DUE_DEPTH].last = 1'b1;
            return taken;
        endfunction

        function void check_beat(beat_t got);
            beat_t want;
            if (due_count == 0)
            begin
                $error("unexpected beat: kind %0d tx_byte %02h outcome %0d last %0d",
                       got.kind, got.tx_byte, got.outcome, got.last);
                fails++;
                return;
            end
            want = due_beats[due_head];
            due_head = (due_head + 1) % DUE_DEPTH;
            due_count--;
            if (got.kind !== want.kind)
            begin
                $error("kind: expected %0d, got %0d", want.kind, got.kind);
                fails++;
            end
            if (got.tx_byte !== want.tx_byte)
            begin
                $error("tx_byte: expected %02h, got %02h", want.tx_byte, got.tx_byte);
                fails++;
            end
            if (got.outcome !== want.outcome)
            begin
                $error("outcome: expected %0d, got %0d", want.outcome, got.outcome);
                fails++;
            end
            if (got.last !== want.last)
            begin
                $error("last: expected %0d, got %0d", want.last, got.last);
                fails++;
            end
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic [1:0]            func = FUNC_LOAD;
    logic [7:0]            data_byte = 8'h00;
    logic                  init_flag = 1'b0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic                  kind;
    logic [7:0]            tx_byte;
    logic [1:0]            outcome;
    logic                  last;

    exchange_scoreboard sb = new();
    bit quiet = 1'b0;
    int stall_left = 0;
    int taken_items = 0;

    logic [15:0] plan_cfg [6][5] = '{
        '{16'd1, 16'd2, 16'd1, 16'd1, 16'd2},
        '{16'd1, 16'd1, 16'd1, 16'd1, 16'd1},
        '{16'd3, 16'd6, 16'd2, 16'd3, 16'd3},
        '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd15},
        '{16'd2, 16'd4, 16'd1, 16'd2, 16'd15},
        '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0}
    };

    stim_t directed_plan [27] = '{
        '{FUNC_TICK,  8'h00, 1'b0},
        '{FUNC_START, 8'h00, 1'b0},
        '{FUNC_LOAD,  8'hFF, 1'b1},
        '{FUNC_START, 8'hFF, 1'b1},
        '{FUNC_RX,    8'h55, 1'b0},
        '{FUNC_TICK,  8'h00, 1'b0},
        '{FUNC_START, 8'h00, 1'b1},
        '{FUNC_TICK,  8'h00, 1'b0},
        '{FUNC_TICK,  8'hFF, 1'b1},
        '{FUNC_TICK,  8'h00, 1'b0},
        '{FUNC_LOAD,  8'h00, 1'b0},
        '{FUNC_LOAD,  8'hFF, 1'b0},
        '{FUNC_LOAD,  8'h41, 1'b0},
        '{FUNC_START, 8'h00, 1'b0},
        '{FUNC_TICK,  8'h00, 1'b0},
        '{FUNC_TICK,  8'h00, 1'b0},
        '{FUNC_TICK,  8'h00, 1'b0},
        '{FUNC_TICK,  8'h00, 1'b0},
        '{FUNC_TICK,  8'h00, 1'b0},
        '{FUNC_RX,    8'h00, 1'b0},
        '{FUNC_RX,    8'hFF, 1'b1},
        '{FUNC_RX,    8'h41, 1'b0},
        '{FUNC_RX,    CHAR_CR, 1'b0},
        '{FUNC_RX,    CHAR_CR, 1'b0},
        '{FUNC_RX,    CHAR_LF, 1'b0},
        '{FUNC_RX,    OK_TEXT[15:8], 1'b0},
        '{FUNC_RX,    OK_TEXT[7:0], 1'b0}
    };

    at_command_transactor dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .func      (func),
        .data_byte (data_byte),
        .init_flag (init_flag),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .kind      (kind),
        .tx_byte   (tx_byte),
        .outcome   (outcome),
        .last      (last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 65)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_beat(beat_t'{kind, tx_byte, outcome, last});
        if (stall_left > 0)
        begin
            out_ready <= 1'b0;
            stall_left--;
        end
        else
        begin
            out_ready <= 1'b1;
            stall_left = pick_gap();
        end
    end

    // valid is only dropped when a gap follows, never within the step that raises it
    task automatic push_item(logic [1:0] f, byte_t d, logic flag);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        func <= f;
        data_byte <= d;
        init_flag <= flag;
        do
            @(posedge clk);
        while (in_ready !== 1'b1);
        if (sb.note_item(f, d, flag))
            taken_items++;
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [15:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        sb.write_reg(idx, value);
    endtask

    task automatic load_settings(int p);
        cfg_write(REG_INIT_ECHO_TIMEOUT, plan_cfg[p][0]);
        cfg_write(REG_ECHO_TIMEOUT, plan_cfg[p][1]);
        cfg_write(REG_GUARD_TIME, plan_cfg[p][2]);
        cfg_write(REG_NOOP_DELAY, plan_cfg[p][3]);
        cfg_write(REG_RETRY_LIMIT, plan_cfg[p][4]);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (sb.due_count != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    task automatic tick_burst();
        repeat ($urandom_range(1, 4))
            push_item(FUNC_TICK, byte_t'($urandom), 1'($urandom));
    endtask

    task automatic noise_item();
        push_item(2'($urandom), byte_t'($urandom), 1'($urandom));
    endtask

    task automatic send_text(logic [39:0] text, int n);
        int i;
        for (i = 0; i < n; i++)
            push_item(FUNC_RX, text[8 * (n - 1 - i) +: 8], 1'($urandom));
    endtask

    // one exchange: load a command, start it, then answer as a modem would
    task automatic run_exchange();
        int    n;
        int    i;
        int    steps;
        int    r;
        int    lead;
        int    echo_n;
        byte_t echo_buf [WIN_DEPTH + 1];
        quiet = ($urandom_range(0, 4) == 0);
        r = $urandom_range(0, 99);
        if (r < 8)
            n = 0;
        else if (r < 16)
            n = $urandom_range(CMD_LEN - 1, CMD_LEN + 2);
        else
            n = $urandom_range(1, 6);
        for (i = 0; i < n; i++)
            push_item(FUNC_LOAD, byte_t'($urandom), 1'($urandom));
        if ($urandom_range(0, 9) == 0)
            noise_item();
        push_item(FUNC_START, byte_t'($urandom), ($urandom_range(0, 2) == 0));
        steps = 0;
        while (sb.xphase != EX_IDLE && steps < 40)
        begin
            steps++;
            r = $urandom_range(0, 99);
            case (sb.xphase)
                EX_SEND:
                    if (r < 65)
                    begin
                        echo_n = 0;
                        if (r > 55)
                        begin
                            echo_buf[0] = byte_t'($urandom);
                            echo_n = 1;
                        end
                        lead = echo_n;
                        for (i = 0; i < sb.cmd_len; i++)
                        begin
                            echo_buf[echo_n] = sb.cmd_mem[i];
                            echo_n++;
                        end
                        echo_buf[echo_n] = CHAR_CR;
                        echo_buf[echo_n + 1] = CHAR_CR;
                        echo_buf[echo_n + 2] = CHAR_LF;
                        echo_n += 3;
                        if (r < 8)
                            echo_buf[$urandom_range(lead, echo_n - 1)] ^= 8'h20;
                        for (i = 0; i < echo_n; i++)
                            push_item(FUNC_RX, echo_buf[i], 1'($urandom));
                    end
                    else if (r < 85)
                        tick_burst();
                    else
                        noise_item();
                EX_REPLY:
                    if (r < 40)
                        send_text(OK_TEXT, 2);
                    else if (r < 65)
                        send_text(ERROR_TEXT, 5);
                    else if (r < 78)
                        push_item(FUNC_RX, byte_t'($urandom), 1'($urandom));
                    else
                        tick_burst();
                default:
                    if (r < 85)
                        tick_burst();
                    else
                        noise_item();
            endcase
        end
    endtask

    initial
    begin
        int p;
        int goal;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        load_settings(0);
        foreach (directed_plan[k])
            push_item(directed_plan[k].f, directed_plan[k].d, directed_plan[k].flag);
        for (p = 1; p < 6; p++)
        begin
            wait_drained();
            load_settings(p);
            goal = taken_items + 80;
            while (taken_items < goal)
                run_exchange();
        end
        wait_drained();
        if (sb.fails == 0)
            $display("at_command_transactor: match");
        else
            $display("at_command_transactor: mismatch");
        $finish;
    end

    initial
    begin
        #50_000_000;
        $display("at_command_transactor: mismatch");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/atct_pkg.sv
hw/rtl/atct_front.sv
hw/rtl/atct_queue.sv
hw/rtl/atct_back.sv
hw/rtl/at_command_transactor.sv
tb/sv/at_command_transactor_tb.sv
